>>> hw/rtl/sine_table_interpolator_unit_macros.svh
// ----------------------------------------------------------------------------
// sine table interpolator assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SINE_TABLE_INTERPOLATOR_UNIT_MACROS_SVH
`define SINE_TABLE_INTERPOLATOR_UNIT_MACROS_SVH

// same-cycle implication
`define STI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sine table interpolator assertion failed");

// next-cycle implication
`define STI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sine table interpolator assertion failed");

`endif

>>> hw/rtl/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg
// shared constants and types of the sine table interpolator
// ----------------------------------------------------------------------------
package sti_pkg;

	localparam int unsigned ANGLE_W    = 32;
	localparam int unsigned SINE_W     = 16;
	localparam int unsigned PHASE_W    = 56;
	localparam int unsigned PHASE_DROP = 16;
	localparam int unsigned FRAC_W     = 40;

	// 1/(2*pi) in unsigned q0.32
	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

	// taylor series denominators, innermost first
	localparam logic [63:0] SERIES_DIV [6] = '{
		64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
	};

	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_s3;
		logic load_s4;
	} stage_en_t;

endpackage

>>> hw/rtl/sine_table_interpolator_unit.sv
// ----------------------------------------------------------------------------
// sine_table_interpolator_unit
// pipelined sine by table lookup with linear interpolation
//
// input channel: angle, signed q8.24 radians, on in_valid / in_ready
// output channel: sine_value, signed q1.15, on out_valid / out_ready
// every angle is valid; only the phase within one turn matters
// four register stages: angle multiply, table position multiply,
// registered read of both table entries, blend multiply and saturate
// throughput: one item per cycle while out_ready stays high, set by the
// four stages each taking one item a cycle; no state carries between items
// when out_ready is low, stages fill up behind the waiting result and
// in_ready falls only once all four stages hold an item
// reset clears the stage valid bits; the table is constant
// ----------------------------------------------------------------------------
`include "sine_table_interpolator_unit_macros.svh"

module sine_table_interpolator_unit #(
	parameter int unsigned TABLE_ENTRIES = 512,
	parameter int unsigned WEIGHT_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [sti_pkg::ANGLE_W-1:0]  angle,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sti_pkg::SINE_W-1:0]   sine_value
);

	localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

	sti_pkg::stage_en_t en;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic go_s1;
	logic go_s2;
	logic go_s3;
	logic go_s4;

	logic        [IdxW-1:0]             k_s2;
	logic        [WEIGHT_BITS-1:0]      w_s2;
	logic        [WEIGHT_BITS-1:0]      w_s3;
	logic signed [sti_pkg::SINE_W-1:0]  lo_s3;
	logic signed [sti_pkg::SINE_W-1:0]  hi_s3;
	logic signed [sti_pkg::SINE_W-1:0]  sine_s4;

	assign go_s4 = !valid_s4 || out_ready;
	assign go_s3 = !valid_s3 || go_s4;
	assign go_s2 = !valid_s2 || go_s3;
	assign go_s1 = !valid_s1 || go_s2;

	assign en.load_s1 = go_s1 && in_valid;
	assign en.load_s2 = go_s2 && valid_s1;
	assign en.load_s3 = go_s3 && valid_s2;
	assign en.load_s4 = go_s4 && valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (go_s1) begin
				valid_s1 <= in_valid;
			end
			if (go_s2) begin
				valid_s2 <= valid_s1;
			end
			if (go_s3) begin
				valid_s3 <= valid_s2;
			end
			if (go_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	sti_phase #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.WEIGHT_BITS   (WEIGHT_BITS)
	) u_phase (
		.clk   (clk),
		.en    (en),
		.angle (angle),
		.k_s2  (k_s2),
		.w_s2  (w_s2)
	);

	sti_sine_rom #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.WEIGHT_BITS   (WEIGHT_BITS)
	) u_rom (
		.clk   (clk),
		.en    (en),
		.k_s2  (k_s2),
		.w_s2  (w_s2),
		.lo_s3 (lo_s3),
		.hi_s3 (hi_s3),
		.w_s3  (w_s3)
	);

	sti_blend #(
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_blend (
		.clk     (clk),
		.en      (en),
		.lo_s3   (lo_s3),
		.hi_s3   (hi_s3),
		.w_s3    (w_s3),
		.sine_s4 (sine_s4)
	);

	assign in_ready   = go_s1;
	assign out_valid  = valid_s4;
	assign sine_value = sine_s4;

	// backpressure only reaches the input once every stage holds an item
	`STI_ASSERT_NOW(a_full_when_blocked, !in_ready, valid_s1 && valid_s2 && valid_s3 && valid_s4)
	`STI_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, valid_s1)
	`STI_ASSERT_NEXT(a_s1_moves_on, valid_s1 && en.load_s2, valid_s2)

endmodule

>>> hw/rtl/sti_phase.sv
// ----------------------------------------------------------------------------
// sti_phase
// angle to turns multiply, then turns to table index and blend weight
// ----------------------------------------------------------------------------
module sti_phase #(
	parameter int unsigned TABLE_ENTRIES = 512,
	parameter int unsigned WEIGHT_BITS   = 16,
	localparam int unsigned IdxW         = $clog2(TABLE_ENTRIES)
) (
	input  logic                                   clk,
	input  sti_pkg::stage_en_t                     en,
	input  logic signed [sti_pkg::ANGLE_W-1:0]     angle,
	output logic        [IdxW-1:0]                 k_s2,
	output logic        [WEIGHT_BITS-1:0]          w_s2
);

	localparam int unsigned ProdW = sti_pkg::ANGLE_W + 31;
	localparam int unsigned PosW  = sti_pkg::FRAC_W + IdxW;

	logic signed [30:0]                  inv_c;
	logic signed [ProdW-1:0]             prod;
	logic        [sti_pkg::PHASE_W-1:0]  phase_s1;
	logic        [sti_pkg::FRAC_W-1:0]   phase40;
	logic        [PosW-1:0]              pos;

	assign inv_c = $signed({1'b0, sti_pkg::INV_TWO_PI_Q32});
	assign prod  = angle * inv_c;

	always_ff @(posedge clk) begin
		if (en.load_s1) begin
			phase_s1 <= prod[sti_pkg::PHASE_W-1:0];
		end
	end

	assign phase40 = phase_s1[sti_pkg::PHASE_W-1:sti_pkg::PHASE_DROP];
	assign pos     = PosW'(phase40) * PosW'(TABLE_ENTRIES);

	always_ff @(posedge clk) begin
		if (en.load_s2) begin
			k_s2 <= pos[PosW-1:sti_pkg::FRAC_W];
			w_s2 <= pos[sti_pkg::FRAC_W-1 -: WEIGHT_BITS];
		end
	end

endmodule

>>> hw/rtl/sti_sine_rom.sv
// ----------------------------------------------------------------------------
// sti_sine_rom
// even and odd banks of the q1.15 sine table, registered read of both ends
// ----------------------------------------------------------------------------
module sti_sine_rom #(
	parameter int unsigned TABLE_ENTRIES = 512,
	parameter int unsigned WEIGHT_BITS   = 16,
	localparam int unsigned IdxW         = $clog2(TABLE_ENTRIES)
) (
	input  logic                                  clk,
	input  sti_pkg::stage_en_t                    en,
	input  logic        [IdxW-1:0]                k_s2,
	input  logic        [WEIGHT_BITS-1:0]         w_s2,
	output logic signed [sti_pkg::SINE_W-1:0]     lo_s3,
	output logic signed [sti_pkg::SINE_W-1:0]     hi_s3,
	output logic        [WEIGHT_BITS-1:0]         w_s3
);

	localparam int unsigned EvenN = TABLE_ENTRIES / 2 + 1;
	localparam int unsigned OddN  = (TABLE_ENTRIES + 1) / 2;
	localparam int unsigned EvenW = $clog2(EvenN);
	localparam int unsigned OddW  = $clog2(OddN);
	localparam logic [63:0] N64   = 64'(TABLE_ENTRIES);
	localparam logic [63:0] NHalf = 64'(TABLE_ENTRIES / 2);

	function automatic logic signed [sti_pkg::SINE_W-1:0] entry_value(input int unsigned j);
		logic [63:0] q;
		logic [63:0] x;
		logic [63:0] th;
		logic [63:0] t2;
		logic [63:0] h;
		logic [63:0] s;
		logic [63:0] mag;
		logic        neg;
		longint      r;
		q   = 64'(j) << 2;
		neg = 1'b0;
		if (q > 2 * N64) begin
			neg = 1'b1;
			q   = q - 2 * N64;
		end
		if (q > N64) begin
			q = 2 * N64 - q;
		end
		x  = ((q << 30) + NHalf) / N64;
		th = (x * sti_pkg::HALF_PI_Q30) >> 30;
		t2 = (th * th) >> 30;
		h  = sti_pkg::ONE_Q30;
		for (int i = 0; i < 6; i++) begin
			h = sti_pkg::ONE_Q30 - ((t2 * h) >> 30) / sti_pkg::SERIES_DIV[i];
		end
		s   = (th * h) >> 30;
		mag = (s + (64'd1 << 14)) >> 15;
		r   = neg ? -longint'(mag) : longint'(mag);
		if (r > 32767) begin
			r = 32767;
		end else if (r < -32768) begin
			r = -32768;
		end
		return sti_pkg::SINE_W'(r);
	endfunction

	logic signed [sti_pkg::SINE_W-1:0] even_rom [EvenN];
	logic signed [sti_pkg::SINE_W-1:0] odd_rom  [OddN];

	for (genvar e = 0; e < EvenN; e++) begin : g_even
		assign even_rom[e] = entry_value(2 * e);
	end

	for (genvar o = 0; o < OddN; o++) begin : g_odd
		assign odd_rom[o] = entry_value(2 * o + 1);
	end

	logic [IdxW-1:0]  k_half;
	logic [IdxW-1:0]  even_full;
	logic [EvenW-1:0] even_addr;
	logic [OddW-1:0]  odd_addr;

	assign k_half    = k_s2 >> 1;
	assign even_full = k_half + IdxW'(k_s2[0]);
	assign even_addr = even_full[EvenW-1:0];
	assign odd_addr  = k_half[OddW-1:0];

	always_ff @(posedge clk) begin
		if (en.load_s3) begin
			if (k_s2[0]) begin
				lo_s3 <= odd_rom[odd_addr];
				hi_s3 <= even_rom[even_addr];
			end else begin
				lo_s3 <= even_rom[even_addr];
				hi_s3 <= odd_rom[odd_addr];
			end
			w_s3 <= w_s2;
		end
	end

endmodule

>>> hw/rtl/sti_blend.sv
// ----------------------------------------------------------------------------
// sti_blend
// linear blend of two table entries, round half up, saturate to q1.15
// ----------------------------------------------------------------------------
module sti_blend #(
	parameter int unsigned WEIGHT_BITS = 16
) (
	input  logic                                  clk,
	input  sti_pkg::stage_en_t                    en,
	input  logic signed [sti_pkg::SINE_W-1:0]     lo_s3,
	input  logic signed [sti_pkg::SINE_W-1:0]     hi_s3,
	input  logic        [WEIGHT_BITS-1:0]         w_s3,
	output logic signed [sti_pkg::SINE_W-1:0]     sine_s4
);

	localparam int unsigned DiffW = sti_pkg::SINE_W + 1;
	localparam int unsigned ProdW = WEIGHT_BITS + DiffW + 1;
	localparam int unsigned AccW  = WEIGHT_BITS + 19;
	localparam int unsigned ResW  = AccW - WEIGHT_BITS;

	logic signed [DiffW-1:0]       diff;
	logic signed [WEIGHT_BITS:0]   wt;
	logic signed [ProdW-1:0]       prod;
	logic signed [AccW-1:0]        acc;
	logic signed [ResW-1:0]        res;
	logic signed [sti_pkg::SINE_W-1:0] sat;

	assign diff = DiffW'(hi_s3) - DiffW'(lo_s3);
	assign wt   = $signed({1'b0, w_s3});
	assign prod = diff * wt;
	assign acc  = (AccW'(lo_s3) <<< WEIGHT_BITS) + AccW'(prod)
		+ (AccW'(1) <<< (WEIGHT_BITS - 1));
	assign res  = $signed(acc[AccW-1:WEIGHT_BITS]);

	always_comb begin
		if (res > ResW'(32767)) begin
			sat = 16'sh7fff;
		end else if (res < -ResW'(32768)) begin
			sat = -16'sh8000;
		end else begin
			sat = res[sti_pkg::SINE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.load_s4) begin
			sine_s4 <= sat;
		end
	end

endmodule

>>> sim/sine_table_interpolator_unit_test.sv
// ----------------------------------------------------------------------------
// sine_table_interpolator_unit_test
// drives signed q8.24 angles into the interpolator and checks every
// q1.15 sine against a bit-exact table and blend model kept here, or
// a typed sine for three rows; a short table of edge angles comes first,
// then random angles under three idle patterns on the sender and the receiver
// ----------------------------------------------------------------------------
module sine_table_interpolator_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TBL_N     = 512;
	localparam int unsigned WGT_BITS  = 16;
	localparam int          HALF_CLK  = 6;
	localparam int          CYCLE_CAP = 200000;
	localparam int          RAND_PER_PHASE = 650;

	typedef struct packed {
		logic signed [sti_pkg::ANGLE_W-1:0] angle;
		logic                               typed;
		logic signed [sti_pkg::SINE_W-1:0]  sine;
	} angle_row_t;

	typedef struct packed {
		logic signed [sti_pkg::ANGLE_W-1:0] angle;
		logic signed [sti_pkg::SINE_W-1:0]  sine;
	} expected_sine_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic signed [sti_pkg::ANGLE_W-1:0] angle = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic signed [sti_pkg::SINE_W-1:0]  sine_value;

	expected_sine_t sine_expected_q [$];
	int             mismatch_count = 0;
	int             sines_checked = 0;
	int             angles_sent = 0;
	int             cycle_count = 0;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;

	// edge angles: zero, one lsb either side, range ends, quarter turns, bit patterns
	angle_row_t directed_rows [16] = '{
		'{32'sh0000_0000, 1'b1, 16'sd0},
		'{32'sh0000_0001, 1'b1, 16'sd0},
		'{32'shFFFF_FFFF, 1'b1, 16'sd0},
		'{32'sh7FFF_FFFF, 1'b0, 16'sd0},
		'{32'sh8000_0000, 1'b0, 16'sd0},
		'{32'sd26353589,  1'b0, 16'sd0},
		'{32'sd52707179,  1'b0, 16'sd0},
		'{32'sd79060768,  1'b0, 16'sd0},
		'{32'sd105414357, 1'b0, 16'sd0},
		'{-32'sd26353589, 1'b0, 16'sd0},
		'{-32'sd52707179, 1'b0, 16'sd0},
		'{32'sh5555_5555, 1'b0, 16'sd0},
		'{32'shAAAA_AAAA, 1'b0, 16'sd0},
		'{32'sh0000_FFFF, 1'b0, 16'sd0},
		'{32'shFFFF_0000, 1'b0, 16'sd0},
		'{32'sh7F00_0000, 1'b0, 16'sd0}
	};

	sine_table_interpolator_unit #(
		.TABLE_ENTRIES(TBL_N),
		.WEIGHT_BITS  (WGT_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.angle     (angle),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sine_value(sine_value)
	);

	always #(HALF_CLK) clk = ~clk;

	function automatic longint clamp_q15(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic longint sine_table_value(input longint unsigned j);
		longint unsigned n, q, x, th, t2, h, s, mag;
		bit              neg;
		int              i;
		n = TBL_N;
		q = 4 * j;
		neg = 1'b0;
		// fold the turn into the first quadrant
		if (q > 2 * n) begin
			neg = 1'b1;
			q -= 2 * n;
		end
		if (q > n)
			q = 2 * n - q;
		x = ((q << 30) + n / 2) / n;
		th = (x * sti_pkg::HALF_PI_Q30) >> 30;
		t2 = (th * th) >> 30;
		h = sti_pkg::ONE_Q30;
		for (i = 0; i < 6; i++)
			h = sti_pkg::ONE_Q30 - ((t2 * h) >> 30) / sti_pkg::SERIES_DIV[i];
		s = (th * h) >> 30;
		mag = (s + 64'd16384) >> 15;
		return clamp_q15(neg ? -longint'(mag) : longint'(mag));
	endfunction

	function automatic logic signed [15:0] predict_sine(input logic signed [31:0] a);
		longint          prod, lo, hi, acc;
		longint unsigned phase, pos, k, w;
		prod = longint'(a) * longint'(sti_pkg::INV_TWO_PI_Q32);
		phase = prod;
		phase &= (64'd1 << sti_pkg::PHASE_W) - 64'd1;
		pos = (phase >> sti_pkg::PHASE_DROP) * TBL_N;
		k = pos >> sti_pkg::FRAC_W;
		w = (pos & ((64'd1 << sti_pkg::FRAC_W) - 64'd1)) >> (sti_pkg::FRAC_W - WGT_BITS);
		lo = sine_table_value(k);
		hi = sine_table_value(k + 1);
		acc = lo * ((longint'(1) << WGT_BITS) - longint'(w)) + hi * longint'(w)
			+ (longint'(1) << (WGT_BITS - 1));
		return 16'(clamp_q15(acc >>> WGT_BITS));
	endfunction

	task automatic report_mismatch(input string what, input logic signed [31:0] a,
		input logic signed [15:0] got, input logic signed [15:0] want);
		$display("mismatch %0s: angle %h got %0d expected %0d", what, a, got, want);
		mismatch_count++;
	endtask

	task automatic send_angle(input logic signed [31:0] a, input bit typed,
		input logic signed [15:0] typed_sine);
		expected_sine_t item;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		item.angle = a;
		item.sine = typed ? typed_sine : predict_sine(a);
		sine_expected_q.push_back(item);
		in_valid <= 1'b1;
		angle <= a;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		angles_sent++;
	endtask

	function automatic logic signed [31:0] random_angle();
		int pick, m;
		pick = $urandom_range(0, 3);
		case (pick)
			0, 1: begin
				return $urandom;
			end
			2: begin
				// within one turn either side of zero
				return int'($urandom_range(0, 210828714)) - 105414357;
			end
			default: begin
				// near a table node, so the weight sits at its ends
				m = $urandom_range(0, 2047) - 1024;
				return m * 205887 + int'($urandom_range(0, 15)) - 8;
			end
		endcase
	endfunction

	task automatic check_sine(input logic signed [15:0] got);
		expected_sine_t want;
		if (sine_expected_q.size() == 0) begin
			report_mismatch("unexpected item", 'x, got, 'x);
		end else begin
			want = sine_expected_q.pop_front();
			if (got !== want.sine)
				report_mismatch("sine_value", want.angle, got, want.sine);
			sines_checked++;
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready)
			check_sine(sine_value);
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	initial begin
		while (cycle_count < CYCLE_CAP) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		send_idle_pct = 21;
		recv_idle_pct = 46;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_angle(directed_rows[i].angle, directed_rows[i].typed, directed_rows[i].sine);

		repeat (RAND_PER_PHASE) send_angle(random_angle(), 1'b0, '0);
		send_idle_pct = 46;
		recv_idle_pct = 21;
		repeat (RAND_PER_PHASE) send_angle(random_angle(), 1'b0, '0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (RAND_PER_PHASE) send_angle(random_angle(), 1'b0, '0);
		in_valid <= 1'b0;

		while (sine_expected_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("sent %0d angles (%0d edge cases, rest random), checked %0d sines",
			angles_sent, $size(directed_rows), sines_checked);
		$display("idle patterns: sender 21/receiver 46, sender 46/receiver 21, none");
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
